// ===== src/dat_pkg.sv =====
package dat_pkg;

    // Default width of every stored filter value.
    localparam int STATE_WIDTH_DEF = 32;

    // Configuration register width and reset values (Q7.24, unsigned).
    localparam int CFG_WIDTH = 31;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_WIDTH-1:0] ANGLE_Q_RESET = 31'd16777;
    localparam logic [CFG_WIDTH-1:0] BIAS_Q_RESET = 31'd50332;
    localparam logic [CFG_WIDTH-1:0] MEAS_R_RESET = 31'd8388608;
    localparam logic [CFG_WIDTH-1:0] PERIOD_RESET = 31'd313734;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ANGLE_Q = 2'd0,
        CFG_BIAS_Q  = 2'd1,
        CFG_MEAS_R  = 2'd2,
        CFG_PERIOD  = 2'd3
    } cfg_index_t;

    // Current configuration as seen by both axis lanes.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] qa;
        logic [CFG_WIDTH-1:0] qg;
        logic [CFG_WIDTH-1:0] rr;
        logic [CFG_WIDTH-1:0] dt;
    } dat_cfg_t;

    // Control from the merge stage to one axis lane.
    typedef struct packed {
        logic start;
        logic ack;
    } dat_lane_ctl_t;

    // Sequencer steps of one axis lane.
    typedef enum logic [3:0] {
        L_IDLE,
        L_RATE_MUL,
        L_P00_MUL,
        L_P01_MUL,
        L_P11_MUL,
        L_GAIN_DIV,
        L_K0T0_MUL,
        L_K0T1_MUL,
        L_K1T0_MUL,
        L_K1T1_MUL,
        L_K0ERR_MUL,
        L_K1ERR_MUL,
        L_DONE
    } lane_state_t;

endpackage

// ===== src/dat_mul.sv =====
module dat_mul #(
    parameter int SW = dat_pkg::STATE_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic signed [((SW > 32) ? SW : 32)-1:0]       a,
    input  logic signed [((SW > 32) ? SW : 32)-1:0]       b,
    output logic                                          done,
    output logic signed [SW-1:0]                          res
);
    import dat_pkg::*;

    localparam int IW = (SW > 32) ? SW : 32;
    localparam int CH = (IW + 15) / 16;
    localparam int MBW = CH * 16;
    localparam int AW = IW + MBW;
    localparam int RW = AW + 1;
    localparam int NW = AW - 23;
    localparam int CW = $clog2(CH + 1);

    logic          busy_reg;
    logic          fin_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [IW-1:0] ma_reg;
    logic [MBW-1:0] mb_reg;
    logic [AW-1:0] acc_reg;
    logic signed [SW-1:0] res_reg;

    logic [IW+15:0] prod_w;
    logic [RW-1:0]  rsum_w;
    logic [NW-1:0]  rnd_w;
    logic [NW-1:0]  cap_w;
    logic [SW:0]    mag_w;
    logic [SW:0]    sres_w;

    // One 16-bit slice of the multiplier operand per cycle, most significant first.
    assign prod_w = ma_reg * mb_reg[MBW-1 -: 16];

    // Round to nearest (ties away from zero), drop 24 fraction bits, clamp.
    always_comb
    begin
        rsum_w = {1'b0, acc_reg} + RW'(64'd1 << 23);
        rnd_w = rsum_w[RW-1:24];
        cap_w = NW'(64'd1 << (SW - 1)) - NW'(!neg_reg);
        mag_w = (rnd_w > cap_w) ? cap_w[SW:0] : rnd_w[SW:0];
        sres_w = neg_reg ? (~mag_w + 1'b1) : mag_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(CH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    // Operand magnitudes and the accumulating product.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[IW-1] ^ b[IW-1];
            ma_reg <= a[IW-1] ? (~a + 1'b1) : a;
            mb_reg <= MBW'(b[IW-1] ? (~b + 1'b1) : b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg << 16) + AW'(prod_w);
            mb_reg <= mb_reg << 16;
        end
        if (fin_reg)
        begin
            res_reg <= sres_w[SW-1:0];
        end
    end

    assign done = done_reg;
    assign res = res_reg;

endmodule

// ===== src/dat_div.sv =====
module dat_div #(
    parameter int SW = dat_pkg::STATE_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [SW-1:0]                      num,
    input  logic [((SW > 32) ? SW : 32):0]            den,
    output logic                                      done,
    output logic signed [SW-1:0]                      quo
);
    import dat_pkg::*;

    localparam int IW = (SW > 32) ? SW : 32;
    localparam int DW = IW + 1;
    localparam int NB = SW + 24;
    localparam int QW = SW + 1;
    localparam int CW = $clog2(NB + 1);

    logic          busy_reg;
    logic          fin_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          ovf_reg;
    logic [NB-1:0] dvd_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic signed [SW-1:0] res_reg;

    logic [DW:0]   rsh_w;
    logic          ge_w;
    logic [DW:0]   rsub_w;
    logic [QW-1:0] cap_w;
    logic [QW-1:0] mag_w;
    logic [QW-1:0] sres_w;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rsh_w = {rem_reg, dvd_reg[NB-1]};
        ge_w = (rsh_w >= {1'b0, den_reg});
        rsub_w = rsh_w - {1'b0, den_reg};
        cap_w = QW'(64'd1 << (SW - 1)) - QW'(!neg_reg);
        mag_w = (ovf_reg || (q_reg > cap_w)) ? cap_w : q_reg;
        sres_w = neg_reg ? (~mag_w + 1'b1) : mag_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[SW-1];
            dvd_reg <= {(num[SW-1] ? (~num + 1'b1) : num), 24'd0};
            den_reg <= den;
            rem_reg <= '0;
            q_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge_w ? rsub_w[DW-1:0] : rsh_w[DW-1:0];
            q_reg <= {q_reg[QW-2:0], ge_w};
            ovf_reg <= ovf_reg | q_reg[QW-1];
        end
        if (fin_reg)
        begin
            res_reg <= sres_w[SW-1:0];
        end
    end

    assign done = done_reg;
    assign quo = res_reg;

endmodule

// ===== src/dat_lane.sv =====
module dat_lane #(
    parameter int SW = dat_pkg::STATE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dat_pkg::dat_cfg_t      cfg,
    input  dat_pkg::dat_lane_ctl_t ctl,
    input  logic signed [31:0]     rate_in,
    input  logic signed [31:0]     meas_in,
    output logic                   done,
    output logic signed [31:0]     angle_out,
    output logic signed [31:0]     rate_out
);
    import dat_pkg::*;

    localparam int IW = (SW > 32) ? SW : 32;
    localparam int WW = IW + 3;
    localparam int EW = IW + 2;
    localparam logic signed [WW-1:0] SMAX_W = WW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SMIN_W = -SMAX_W - WW'(1);
    localparam logic signed [WW-1:0] OMAX_W = WW'(64'sd2147483647);
    localparam logic signed [WW-1:0] OMIN_W = WW'(-64'sd2147483648);
    localparam logic signed [SW-1:0] P_ONE = (SW >= 26) ? SW'(64'sd1 <<< 24) : SMAX_W[SW-1:0];

    // Clamp a wide intermediate to the stored width.
    function automatic logic signed [SW-1:0] sat_w(input logic signed [WW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX_W)
            r = SMAX_W[SW-1:0];
        else if (v < SMIN_W)
            r = SMIN_W[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    // Sign-extend a stored value to the working width.
    function automatic logic signed [WW-1:0] sx(input logic signed [SW-1:0] v);
        return WW'(v);
    endfunction

    // Clamp a stored value to the 32-bit result fields.
    function automatic logic signed [31:0] out32(input logic signed [SW-1:0] v);
        logic signed [WW-1:0] w;
        logic signed [31:0] r;
        w = WW'(v);
        if (w > OMAX_W)
            r = OMAX_W[31:0];
        else if (w < OMIN_W)
            r = OMIN_W[31:0];
        else
            r = w[31:0];
        return r;
    endfunction

    lane_state_t state_reg, state_next;
    logic issued_reg, issued_next;
    logic signed [SW-1:0] angle_reg, angle_next;
    logic signed [SW-1:0] bias_reg, bias_next;
    logic signed [SW-1:0] p_reg [4];
    logic signed [SW-1:0] p_next [4];
    logic signed [31:0] g_reg, g_next;
    logic signed [31:0] z_reg, z_next;
    logic signed [SW-1:0] err_reg, err_next;
    logic signed [EW-1:0] e_reg, e_next;
    logic signed [SW-1:0] k0_reg, k0_next;
    logic signed [SW-1:0] k1_reg, k1_next;
    logic signed [SW-1:0] t0_reg, t0_next;
    logic signed [SW-1:0] t1_reg, t1_next;

    logic signed [WW-1:0] qa_w, qg_w, g_w;
    logic signed [IW-1:0] dt_w;
    logic signed [SW-1:0] rc_w;
    logic                 mul_op_w;
    logic                 mul_start_w;
    logic signed [IW-1:0] mul_a_w, mul_b_w;
    logic                 mul_done_w;
    logic signed [SW-1:0] mul_res_w;
    logic                 div_start_w;
    logic                 div0_done_w, div1_done_w;
    logic signed [SW-1:0] k0_w, k1_w;

    assign qa_w = $signed(WW'(cfg.qa));
    assign qg_w = $signed(WW'(cfg.qg));
    assign dt_w = $signed(IW'(cfg.dt));
    assign g_w = WW'(g_reg);
    assign rc_w = sat_w(g_w - sx(bias_reg));

    // Multiplier operands for each step.
    always_comb
    begin
        mul_op_w = 1'b1;
        mul_a_w = '0;
        mul_b_w = dt_w;
        case (state_reg)
            L_RATE_MUL:
            begin
                mul_a_w = IW'(rc_w);
            end
            L_P00_MUL:
            begin
                mul_a_w = IW'(sat_w(qa_w - sx(p_reg[1]) - sx(p_reg[2])));
            end
            L_P01_MUL:
            begin
                mul_a_w = IW'(sat_w(-sx(p_reg[3])));
            end
            L_P11_MUL:
            begin
                mul_a_w = IW'(sat_w(qg_w));
            end
            L_K0T0_MUL:
            begin
                mul_a_w = IW'(k0_reg);
                mul_b_w = IW'(t0_reg);
            end
            L_K0T1_MUL:
            begin
                mul_a_w = IW'(k0_reg);
                mul_b_w = IW'(t1_reg);
            end
            L_K1T0_MUL:
            begin
                mul_a_w = IW'(k1_reg);
                mul_b_w = IW'(t0_reg);
            end
            L_K1T1_MUL:
            begin
                mul_a_w = IW'(k1_reg);
                mul_b_w = IW'(t1_reg);
            end
            L_K0ERR_MUL:
            begin
                mul_a_w = IW'(k0_reg);
                mul_b_w = IW'(err_reg);
            end
            L_K1ERR_MUL:
            begin
                mul_a_w = IW'(k1_reg);
                mul_b_w = IW'(err_reg);
            end
            default:
            begin
                mul_op_w = 1'b0;
            end
        endcase
    end

    assign mul_start_w = mul_op_w && !issued_reg;

    // Step sequencer and state updates.
    always_comb
    begin
        state_next = state_reg;
        issued_next = issued_reg;
        angle_next = angle_reg;
        bias_next = bias_reg;
        p_next = p_reg;
        g_next = g_reg;
        z_next = z_reg;
        err_next = err_reg;
        e_next = e_reg;
        k0_next = k0_reg;
        k1_next = k1_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        div_start_w = 1'b0;
        if (mul_start_w)
            issued_next = 1'b1;
        case (state_reg)
            L_IDLE:
            begin
                if (ctl.start)
                begin
                    g_next = rate_in;
                    z_next = meas_in;
                    state_next = L_RATE_MUL;
                end
            end
            L_RATE_MUL:
            begin
                if (mul_done_w)
                begin
                    angle_next = sat_w(sx(angle_reg) + sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_P00_MUL;
                end
            end
            L_P00_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[0] = sat_w(sx(p_reg[0]) + sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_P01_MUL;
                end
            end
            L_P01_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[1] = sat_w(sx(p_reg[1]) + sx(mul_res_w));
                    p_next[2] = sat_w(sx(p_reg[2]) + sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_P11_MUL;
                end
            end
            L_P11_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[3] = sat_w(sx(p_reg[3]) + sx(mul_res_w));
                    err_next = sat_w(WW'(z_reg) - sx(angle_reg));
                    e_next = $signed(EW'(cfg.rr)) + EW'(p_reg[0]);
                    issued_next = 1'b0;
                    state_next = L_GAIN_DIV;
                end
            end
            L_GAIN_DIV:
            begin
                if (!issued_reg)
                begin
                    // A non-positive innovation variance skips the correction.
                    if (e_reg[EW-1] || (e_reg == '0))
                    begin
                        state_next = L_DONE;
                    end
                    else
                    begin
                        div_start_w = 1'b1;
                        issued_next = 1'b1;
                        t0_next = p_reg[0];
                        t1_next = p_reg[1];
                    end
                end
                else if (div0_done_w && div1_done_w)
                begin
                    k0_next = k0_w;
                    k1_next = k1_w;
                    issued_next = 1'b0;
                    state_next = L_K0T0_MUL;
                end
            end
            L_K0T0_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[0] = sat_w(sx(p_reg[0]) - sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_K0T1_MUL;
                end
            end
            L_K0T1_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[1] = sat_w(sx(p_reg[1]) - sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_K1T0_MUL;
                end
            end
            L_K1T0_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[2] = sat_w(sx(p_reg[2]) - sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_K1T1_MUL;
                end
            end
            L_K1T1_MUL:
            begin
                if (mul_done_w)
                begin
                    p_next[3] = sat_w(sx(p_reg[3]) - sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_K0ERR_MUL;
                end
            end
            L_K0ERR_MUL:
            begin
                if (mul_done_w)
                begin
                    angle_next = sat_w(sx(angle_reg) + sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_K1ERR_MUL;
                end
            end
            L_K1ERR_MUL:
            begin
                if (mul_done_w)
                begin
                    bias_next = sat_w(sx(bias_reg) + sx(mul_res_w));
                    issued_next = 1'b0;
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                if (ctl.ack)
                    state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            issued_reg <= 1'b0;
            angle_reg <= '0;
            bias_reg <= '0;
            p_reg[0] <= P_ONE;
            p_reg[1] <= '0;
            p_reg[2] <= '0;
            p_reg[3] <= P_ONE;
        end
        else
        begin
            state_reg <= state_next;
            issued_reg <= issued_next;
            angle_reg <= angle_next;
            bias_reg <= bias_next;
            p_reg <= p_next;
        end
    end

    // Working values of the current word.
    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        z_reg <= z_next;
        err_reg <= err_next;
        e_reg <= e_next;
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
    end

    dat_mul #(.SW(SW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_w),
        .a     (mul_a_w),
        .b     (mul_b_w),
        .done  (mul_done_w),
        .res   (mul_res_w)
    );

    // Both gains share the denominator and run side by side.
    dat_div #(.SW(SW)) u_div_k0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_w),
        .num   (p_reg[0]),
        .den   (e_reg[IW:0]),
        .done  (div0_done_w),
        .quo   (k0_w)
    );

    dat_div #(.SW(SW)) u_div_k1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_w),
        .num   (p_reg[2]),
        .den   (e_reg[IW:0]),
        .done  (div1_done_w),
        .quo   (k1_w)
    );

    assign done = (state_reg == L_DONE);
    assign angle_out = out32(angle_reg);
    assign rate_out = out32(rc_w);

endmodule

// ===== src/dual_axis_tilt_kalman_filter.sv =====
// Channel   Direction  Handshake              Contents
// cfg       in         cfg_we                 cfg_index, cfg_wdata (31-bit Q7.24)
// in        in         in_valid / in_ready    two gyro rates, two accel angles (Q16.16)
// out       out        out_valid / out_ready  two fused angles, two corrected rates
//
// Each lane runs its steps on one shared multiplier and a pair of bit-serial gain dividers;
// a lane whose denominator is not positive skips the correction. No new word is taken
// until the last one has been collected from both lanes.
// Reset clears the estimates, sets the covariance to identity (diagonal saturated when
// STATE_WIDTH < 26) and loads default registers.
// A finished result waits in the output register, and the next word is taken meanwhile;
// while that register is still full, a further finished word holds off the input.
module dual_axis_tilt_kalman_filter #(
    parameter int STATE_WIDTH = dat_pkg::STATE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dat_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dat_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [31:0]                   gyro_rate_x,
    input  logic signed [31:0]                   gyro_rate_y,
    input  logic signed [31:0]                   accel_angle_x,
    input  logic signed [31:0]                   accel_angle_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [31:0]                   fused_angle_a,
    output logic signed [31:0]                   fused_angle_b,
    output logic signed [31:0]                   corrected_rate_a,
    output logic signed [31:0]                   corrected_rate_b
);
    import dat_pkg::*;

    dat_cfg_t cfg_reg;
    logic busy_reg;
    logic out_valid_reg;
    logic signed [31:0] angle_a_reg, angle_b_reg, rate_a_reg, rate_b_reg;

    logic accept_w;
    logic collect_w;
    dat_lane_ctl_t ctl_w;
    logic done_a_w, done_b_w;
    logic signed [31:0] angle_a_w, angle_b_w, rate_a_w, rate_b_w;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qa <= ANGLE_Q_RESET;
            cfg_reg.qg <= BIAS_Q_RESET;
            cfg_reg.rr <= MEAS_R_RESET;
            cfg_reg.dt <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ANGLE_Q: cfg_reg.qa <= cfg_wdata;
                CFG_BIAS_Q:  cfg_reg.qg <= cfg_wdata;
                CFG_MEAS_R:  cfg_reg.rr <= cfg_wdata;
                CFG_PERIOD:  cfg_reg.dt <= cfg_wdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_ready = !busy_reg;
    assign accept_w = in_valid && in_ready;
    assign collect_w = busy_reg && done_a_w && done_b_w && (!out_valid_reg || out_ready);
    assign ctl_w.start = accept_w;
    assign ctl_w.ack = collect_w;

    // Axis A: y gyro with x accel angle.
    dat_lane #(.SW(STATE_WIDTH)) u_lane_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctl       (ctl_w),
        .rate_in   (gyro_rate_y),
        .meas_in   (accel_angle_x),
        .done      (done_a_w),
        .angle_out (angle_a_w),
        .rate_out  (rate_a_w)
    );

    // Axis B: x gyro with y accel angle.
    dat_lane #(.SW(STATE_WIDTH)) u_lane_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctl       (ctl_w),
        .rate_in   (gyro_rate_x),
        .meas_in   (accel_angle_y),
        .done      (done_b_w),
        .angle_out (angle_b_w),
        .rate_out  (rate_b_w)
    );

    // Merge both lanes into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept_w)
                busy_reg <= 1'b1;
            else if (collect_w)
                busy_reg <= 1'b0;
            if (collect_w)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (collect_w)
        begin
            angle_a_reg <= angle_a_w;
            angle_b_reg <= angle_b_w;
            rate_a_reg <= rate_a_w;
            rate_b_reg <= rate_b_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign fused_angle_a = angle_a_reg;
    assign fused_angle_b = angle_b_reg;
    assign corrected_rate_a = rate_a_reg;
    assign corrected_rate_b = rate_b_reg;

`ifndef ASSERT_OFF
    // A lane only reports a finished word while one is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done_a_w || done_b_w) |-> busy_reg)
        else $error("lane done without a word in flight");

    // Collecting a word always presents it at the output next cycle.
    a_collect_out: assert property (@(posedge clk) disable iff (!rst_n)
        collect_w |=> out_valid)
        else $error("collected word not presented");

    // A newly accepted word cannot be finished in the following cycle.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept_w |=> (busy_reg && !done_a_w && !done_b_w))
        else $error("lane finished too early");
`endif

endmodule
